[design/uart_rb_pkg.sv]
`default_nettype none

package uart_rb_pkg;

	// request kinds carried on the input tuser
	typedef enum logic [1:0] {
		REQ_TX_WRITE = 2'd0,
		REQ_RX_READ  = 2'd1,
		REQ_LINE_RX  = 2'd2,
		REQ_TX_READY = 2'd3
	} req_t;

	// result status codes
	typedef enum logic [2:0] {
		ST_OK          = 3'd0,
		ST_TX_FULL     = 3'd1,
		ST_RX_EMPTY    = 3'd2,
		ST_RX_OVERFLOW = 3'd3,
		ST_ECHO_DROP   = 3'd4
	} status_t;

	// result fields known at accept time, before the store read returns
	typedef struct packed {
		logic    rd_ok;
		logic    line_valid;
		logic    tx_irq_enable;
		status_t status;
	} res_ctl_t;

	localparam int unsigned BYTE_W = 8;
	localparam int unsigned OUT_TDATA_W = 24;

endpackage

`default_nettype wire

[design/uart_rb_ram.sv]
`default_nettype none

module uart_rb_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 128
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// one write port, one registered read port; read data holds when idle
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

[design/uart_tx_rx_ring_buffers.sv]
// path: a result word passes the store read stage, then the output register
// throughput: one request word per cycle unless the result stream stalls, set by
// the single read and write port of each store; pointers and flags decide full
// and empty at accept time
// reset clears pointers, interrupt flag, echo enable and pipeline valids;
// the byte stores are not cleared and need no clearing pass
`default_nettype none

module uart_tx_rx_ring_buffers #(
	parameter int unsigned TX_DEPTH = 128,
	parameter int unsigned RX_DEPTH = 128
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// echo enable register
	input  wire logic        cfg_we,
	input  wire logic        cfg_wdata,
	// request stream
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,  // [7:0] data_in
	input  wire logic [1:0]  s_axis_tuser,  // [1:0] req_type
	// result stream
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [23:0]      m_axis_tdata   // [7:0] read_byte, [15:8] line_byte,
	                                        // [16] line_valid, [17] tx_irq_enable,
	                                        // [20:18] status, [23:21] zero
);

	import uart_rb_pkg::*;

	localparam int unsigned TX_AW = $clog2(TX_DEPTH);
	localparam int unsigned RX_AW = $clog2(RX_DEPTH);

	logic             echo_q;
	logic [TX_AW-1:0] tx_head_q, tx_tail_q, tx_head_d, tx_tail_d;
	logic [RX_AW-1:0] rx_head_q, rx_tail_q, rx_head_d, rx_tail_d;
	logic [TX_AW-1:0] tx_head_inc, tx_tail_inc;
	logic [RX_AW-1:0] rx_head_inc, rx_tail_inc;
	logic             irq_q, irq_d;
	logic             tx_full, tx_empty, rx_full, rx_empty;

	logic              tx_we, tx_re, rx_we, rx_re;
	logic [BYTE_W-1:0] tx_rdata, rx_rdata;

	logic     accept, s1_move;
	logic     valid_s1;
	res_ctl_t ctl_d, ctl_s1;
	req_t     req;

	logic              out_valid_q;
	logic [BYTE_W-1:0] read_byte_q, line_byte_q;
	logic              line_valid_q, irq_out_q;
	status_t           status_q;

	// pointer increments with wrap at the ring depth
	assign tx_head_inc = (tx_head_q == TX_AW'(TX_DEPTH - 1)) ? '0 : tx_head_q + 1'b1;
	assign tx_tail_inc = (tx_tail_q == TX_AW'(TX_DEPTH - 1)) ? '0 : tx_tail_q + 1'b1;
	assign rx_head_inc = (rx_head_q == RX_AW'(RX_DEPTH - 1)) ? '0 : rx_head_q + 1'b1;
	assign rx_tail_inc = (rx_tail_q == RX_AW'(RX_DEPTH - 1)) ? '0 : rx_tail_q + 1'b1;

	// one slot kept empty tells full from empty
	assign tx_full  = (tx_tail_inc == tx_head_q);
	assign tx_empty = (tx_head_q == tx_tail_q);
	assign rx_full  = (rx_tail_inc == rx_head_q);
	assign rx_empty = (rx_head_q == rx_tail_q);

	// handshake: s1 drains into the output register when it is free or taken
	assign s1_move       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || s1_move;
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign req           = req_t'(s_axis_tuser);

	// request decode: pointer updates, store accesses and result control
	always_comb begin
		tx_head_d = tx_head_q;
		tx_tail_d = tx_tail_q;
		rx_head_d = rx_head_q;
		rx_tail_d = rx_tail_q;
		irq_d     = irq_q;
		tx_we     = 1'b0;
		tx_re     = 1'b0;
		rx_we     = 1'b0;
		rx_re     = 1'b0;
		ctl_d.rd_ok      = 1'b0;
		ctl_d.line_valid = 1'b0;
		ctl_d.status     = ST_OK;
		if (accept) begin
			unique case (req)
				REQ_TX_WRITE: begin
					if (tx_full) begin
						ctl_d.status = ST_TX_FULL;
					end else begin
						tx_we     = 1'b1;
						tx_tail_d = tx_tail_inc;
						irq_d     = 1'b1;
					end
				end
				REQ_RX_READ: begin
					if (rx_empty) begin
						ctl_d.status = ST_RX_EMPTY;
					end else begin
						rx_re       = 1'b1;
						rx_head_d   = rx_head_inc;
						ctl_d.rd_ok = 1'b1;
					end
				end
				REQ_LINE_RX: begin
					if (rx_full) begin
						ctl_d.status = ST_RX_OVERFLOW;
					end else begin
						rx_we     = 1'b1;
						rx_tail_d = rx_tail_inc;
						if (echo_q) begin
							if (tx_full) begin
								ctl_d.status = ST_ECHO_DROP;
							end else begin
								tx_we     = 1'b1;
								tx_tail_d = tx_tail_inc;
								irq_d     = 1'b1;
							end
						end
					end
				end
				REQ_TX_READY: begin
					if (tx_empty) begin
						irq_d = 1'b0;
					end else begin
						tx_re            = 1'b1;
						tx_head_d        = tx_head_inc;
						ctl_d.line_valid = 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
		ctl_d.tx_irq_enable = irq_d;
	end

	// byte stores
	uart_rb_ram #(
		.WIDTH(BYTE_W),
		.DEPTH(TX_DEPTH)
	) u_tx_ram (
		.clk  (clk),
		.we   (tx_we),
		.waddr(tx_tail_q),
		.wdata(s_axis_tdata),
		.re   (tx_re),
		.raddr(tx_head_q),
		.rdata(tx_rdata)
	);

	uart_rb_ram #(
		.WIDTH(BYTE_W),
		.DEPTH(RX_DEPTH)
	) u_rx_ram (
		.clk  (clk),
		.we   (rx_we),
		.waddr(rx_tail_q),
		.wdata(s_axis_tdata),
		.re   (rx_re),
		.raddr(rx_head_q),
		.rdata(rx_rdata)
	);

	// pointers, interrupt flag and echo enable
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tx_head_q <= '0;
			tx_tail_q <= '0;
			rx_head_q <= '0;
			rx_tail_q <= '0;
			irq_q     <= 1'b0;
			echo_q    <= 1'b0;
		end else begin
			tx_head_q <= tx_head_d;
			tx_tail_q <= tx_tail_d;
			rx_head_q <= rx_head_d;
			rx_tail_q <= rx_tail_d;
			irq_q     <= irq_d;
			if (cfg_we) begin
				echo_q <= cfg_wdata;
			end
		end
	end

	// read stage: control waits here while the store read completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (s1_move) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ctl_s1 <= ctl_d;
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_move) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (s1_move) begin
			read_byte_q  <= ctl_s1.rd_ok ? rx_rdata : '0;
			line_byte_q  <= ctl_s1.line_valid ? tx_rdata : '0;
			line_valid_q <= ctl_s1.line_valid;
			irq_out_q    <= ctl_s1.tx_irq_enable;
			status_q     <= ctl_s1.status;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {3'b000, status_q, irq_out_q, line_valid_q, line_byte_q, read_byte_q};

endmodule

`default_nettype wire
